>>> design/ibq_pkg.sv
// shared types and codes for the indexed byte queue
package ibq_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MV_RD,
      ST_MV_WR,
      ST_FILL,
      ST_RD_WAIT
   } ibq_state_type;

   typedef enum logic [2:0] {
      REQ_ENQUEUE = 3'd0,
      REQ_DEQUEUE = 3'd1,
      REQ_ERASE   = 3'd2,
      REQ_INSERT  = 3'd3,
      REQ_READ    = 3'd4
   } ibq_req_type;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_ROOM  = 2'd2;
   localparam logic [1:0] STAT_RANGE = 2'd3;

   localparam int POS_W  = 4;
   localparam int CNT_W  = 5;
   localparam int DATA_W = 8;
   localparam int FILL_W = 5;

endpackage

>>> design/ibq_ram.sv
// generic single-port-write ram with registered read
module ibq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> design/indexed_byte_queue.sv
// indexed byte queue top level: sequencer around one entry ram
//
//   channel   ports                                   handshake
//   request   req_type req_position req_copy_count    start & !busy
//             req_element_value
//   result    rsp_status rsp_read_value rsp_fill_level rsp_strobe, one cycle
//
// enqueue, rejects, inserts placing no copy: result in the cycle after start
// read: the ram read is registered, then the result is registered
// erase/dequeue: later entries shift down; insert of n > 0 copies: later
//   entries shift up by what fits, then ST_FILL writes the copies
//   each moved entry is read in ST_MV_RD and written in ST_MV_WR
// synchronous reset empties the queue; the ram is not cleared
// results cannot be stalled; busy is low again while a result is shown
module indexed_byte_queue #(
   parameter int CAPACITY = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_type,
   input  logic [ibq_pkg::POS_W-1:0]    req_position,
   input  logic [ibq_pkg::CNT_W-1:0]    req_copy_count,
   input  logic [ibq_pkg::DATA_W-1:0]   req_element_value,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic [ibq_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [ibq_pkg::FILL_W-1:0]   rsp_fill_level
);
   import ibq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OW = $clog2(CAPACITY + 1);
   localparam int CW = ((OW > CNT_W) ? OW : CNT_W) + 1;
   localparam logic [CW-1:0] CAP_X = CW'(CAPACITY);

   ibq_state_type state_ff, state_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic ins_ff, ins_in;
   logic [1:0] stat_ff, stat_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic [FILL_W-1:0] rsp_fill_level_ff, rsp_fill_level_in;

   logic ram_we;
   logic [CW-1:0] ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   logic accept;
   logic [CW-1:0] occ_x, pos_x, cnt_x, room, ins_n, er_pos;
   logic req_range, req_full, req_empty, er_more, ins_more, ins_short;
   logic mv_more, fill_last;
   logic [OW+FILL_W-1:0] fill_ext;

   assign accept    = start && (state_ff == ST_IDLE);
   assign occ_x     = CW'(occ_ff);
   assign pos_x     = CW'(req_position);
   assign cnt_x     = CW'(req_copy_count);
   assign room      = CAP_X - occ_x;
   assign ins_short = cnt_x > room;
   assign ins_n     = ins_short ? room : cnt_x;
   assign req_range = pos_x >= occ_x;
   assign req_full  = occ_x >= CAP_X;
   assign req_empty = occ_ff == '0;
   assign er_pos    = (req_type == REQ_DEQUEUE) ? '0 : pos_x;
   assign er_more   = (er_pos + 1'b1) < occ_x;
   assign ins_more  = (occ_x - 1'b1) > pos_x;
   assign mv_more   = ins_ff ? ((cur_ff - 1'b1) > pos_ff) : ((cur_ff + 1'b1) < occ_x);
   assign fill_last = cnt_ff == CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_DEQUEUE, REQ_ERASE: begin
                     if (!req_empty && !(req_type == REQ_ERASE && req_range) && er_more) begin
                        state_in = ST_MV_RD;
                     end
                  end
                  REQ_INSERT: begin
                     if (!req_range && ins_n != '0) begin
                        state_in = ins_more ? ST_MV_RD : ST_FILL;
                     end
                  end
                  REQ_READ: begin
                     if (!req_range) begin
                        state_in = ST_RD_WAIT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MV_RD: state_in = ST_MV_WR;
         ST_MV_WR: begin
            if (mv_more) begin
               state_in = ST_MV_RD;
            end else begin
               state_in = ins_ff ? ST_FILL : ST_IDLE;
            end
         end
         ST_FILL:    state_in = fill_last ? ST_IDLE : ST_FILL;
         ST_RD_WAIT: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      occ_in            = occ_ff;
      cur_in            = cur_ff;
      cnt_in            = cnt_ff;
      pos_in            = pos_ff;
      val_in            = val_ff;
      ins_in            = ins_ff;
      stat_in           = stat_ff;
      ram_we            = 1'b0;
      ram_waddr         = cur_ff;
      ram_wdata         = val_ff;
      ram_raddr         = cur_ff;
      rsp_strobe_in     = 1'b0;
      rsp_status_in     = STAT_OK;
      rsp_read_value_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               val_in        = req_element_value;
               case (req_type)
                  REQ_ENQUEUE: begin
                     if (req_full) begin
                        rsp_status_in = STAT_ROOM;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = occ_x;
                        ram_wdata = req_element_value;
                        occ_in    = OW'(occ_x + 1'b1);
                     end
                  end
                  REQ_DEQUEUE, REQ_ERASE: begin
                     if (req_empty && req_type == REQ_DEQUEUE) begin
                        rsp_status_in = STAT_EMPTY;
                     end else if (req_range && req_type == REQ_ERASE) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        ins_in  = 1'b0;
                        pos_in  = er_pos;
                        cur_in  = er_pos + 1'b1;
                        stat_in = STAT_OK;
                        if (er_more) begin
                           rsp_strobe_in = 1'b0;
                        end else begin
                           occ_in = OW'(occ_x - 1'b1);
                        end
                     end
                  end
                  REQ_INSERT: begin
                     if (req_range) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        rsp_status_in = ins_short ? STAT_ROOM : STAT_OK;
                        stat_in       = ins_short ? STAT_ROOM : STAT_OK;
                        ins_in        = 1'b1;
                        pos_in        = pos_x;
                        cnt_in        = ins_n;
                        if (ins_n != '0) begin
                           rsp_strobe_in = 1'b0;
                           cur_in        = ins_more ? (occ_x - 1'b1) : (pos_x + 1'b1);
                        end
                     end
                  end
                  REQ_READ: begin
                     if (req_range) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        ram_raddr     = pos_x;
                     end
                  end
                  default: rsp_status_in = STAT_OK;
               endcase
            end
         end
         ST_MV_RD: ram_raddr = cur_ff;
         ST_MV_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            ram_waddr = ins_ff ? (cur_ff + cnt_ff) : (cur_ff - 1'b1);
            cur_in    = ins_ff ? (cur_ff - 1'b1) : (cur_ff + 1'b1);
            if (!mv_more) begin
               if (ins_ff) begin
                  cur_in = pos_ff + 1'b1;
               end else begin
                  occ_in        = OW'(occ_x - 1'b1);
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = stat_ff;
               end
            end
         end
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ff;
            ram_wdata = val_ff;
            cur_in    = cur_ff + 1'b1;
            cnt_in    = cnt_ff - 1'b1;
            occ_in    = OW'(occ_x + 1'b1);
            if (fill_last) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = stat_ff;
            end
         end
         ST_RD_WAIT: begin
            rsp_strobe_in     = 1'b1;
            rsp_read_value_in = ram_rdata;
         end
         default: rsp_strobe_in = 1'b0;
      endcase
   end

   assign fill_ext          = {{FILL_W{1'b0}}, occ_in};
   assign rsp_fill_level_in = fill_ext[FILL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff            <= cur_in;
      cnt_ff            <= cnt_in;
      pos_ff            <= pos_in;
      val_ff            <= val_in;
      ins_ff            <= ins_in;
      stat_ff           <= stat_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_fill_level_ff <= rsp_fill_level_in;
   end

   ibq_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr[AW-1:0]),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr[AW-1:0]),
      .rd_data(ram_rdata)
   );

   assign busy           = state_ff != ST_IDLE;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_fill_level = rsp_fill_level_ff;

endmodule

>>> design/ibq_checker.sv
// port-level checks for the indexed byte queue, bound to the top level
module ibq_checker #(
   parameter int CAPACITY = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_strobe,
   input logic [1:0]                 rsp_status,
   input logic [ibq_pkg::DATA_W-1:0] rsp_read_value,
   input logic [ibq_pkg::FILL_W-1:0] rsp_fill_level
);
   import ibq_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("activity right after reset");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted word neither worked on nor answered");

   a_no_strobe_while_busy_start: assert property (@(posedge clock) disable iff (reset)
      (busy && !$past(busy) && !$past(reset)) |-> !rsp_strobe)
      else $error("result shown on the first busy cycle");

   a_read_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STAT_OK) |-> (rsp_read_value == '0))
      else $error("read value nonzero on failed request");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((CAPACITY > 31) || (int'(rsp_fill_level) <= CAPACITY)))
      else $error("fill level above capacity");

endmodule

bind indexed_byte_queue ibq_checker #(.CAPACITY(CAPACITY)) u_ibq_checker (.*);

>>> verif/indexed_byte_queue_checker.sv
// checker for the indexed byte queue: predicts each result word and compares it
`timescale 1ns / 1ps
module indexed_byte_queue_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [2:0]                   req_type,
   input  logic [ibq_pkg::POS_W-1:0]    req_position,
   input  logic [ibq_pkg::CNT_W-1:0]    req_copy_count,
   input  logic [ibq_pkg::DATA_W-1:0]   req_element_value,
   input  logic                         rsp_strobe,
   input  logic [1:0]                   rsp_status,
   input  logic [ibq_pkg::DATA_W-1:0]   rsp_read_value,
   input  logic [ibq_pkg::FILL_W-1:0]   rsp_fill_level,
   output int                           fail_count,
   output int                           pending_count,
   output int                           result_count
);
   import ibq_pkg::*;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] read_value;
      logic [FILL_W-1:0] fill_level;
   } queue_answer_type;

   logic [DATA_W-1:0] model_entries [CAPACITY];
   int                model_fill;
   queue_answer_type  answer_queue [$];

   function automatic queue_answer_type apply_request(logic [2:0] kind, int pos, int cnt,
                                                      logic [DATA_W-1:0] value);
      queue_answer_type a;
      int               n;
      a = '0;
      a.status = STAT_OK;
      case (kind)
         REQ_ENQUEUE: begin
            if (model_fill >= CAPACITY) a.status = STAT_ROOM;
            else begin
               model_entries[model_fill] = value;
               model_fill++;
            end
         end
         REQ_DEQUEUE: begin
            if (model_fill == 0) a.status = STAT_EMPTY;
            else begin
               for (int i = 0; i < model_fill - 1; i++) model_entries[i] = model_entries[i+1];
               model_fill--;
            end
         end
         REQ_ERASE: begin
            if (pos >= model_fill) a.status = STAT_RANGE;
            else begin
               for (int i = pos; i < model_fill - 1; i++) model_entries[i] = model_entries[i+1];
               model_fill--;
            end
         end
         REQ_INSERT: begin
            if (pos >= model_fill) a.status = STAT_RANGE;
            else begin
               n = cnt;
               if (n > CAPACITY - model_fill) begin
                  n = CAPACITY - model_fill;
                  a.status = STAT_ROOM;
               end
               for (int i = model_fill - 1; i > pos; i--) model_entries[i+n] = model_entries[i];
               for (int i = 0; i < n; i++) model_entries[pos+1+i] = value;
               model_fill += n;
            end
         end
         REQ_READ: begin
            if (pos >= model_fill) a.status = STAT_RANGE;
            else a.read_value = model_entries[pos];
         end
         default: ;
      endcase
      a.fill_level = model_fill[FILL_W-1:0];
      return a;
   endfunction

   always @(posedge clock) begin
      queue_answer_type want;
      int               errs;
      errs = 0;
      if (reset) begin
         model_fill = 0;
         answer_queue.delete();
         fail_count <= 0;
         result_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_strobe) begin
            result_count <= result_count + 1;
            if (answer_queue.size() == 0) begin
               $error("unexpected result word");
               errs++;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %0d actual %0d", want.read_value,
                         rsp_read_value);
                  errs++;
               end
               if (rsp_fill_level !== want.fill_level) begin
                  $error("fill_level: expected %0d actual %0d", want.fill_level,
                         rsp_fill_level);
                  errs++;
               end
            end
         end
         if (start && !busy)
            answer_queue.push_back(apply_request(req_type, int'(req_position),
                                                 int'(req_copy_count), req_element_value));
         pending_count <= answer_queue.size();
         fail_count <= fail_count + errs;
      end
   end

endmodule

>>> verif/testbench.sv
// testbench top for the indexed byte queue: stimulus, idling and verdict
`timescale 1ns / 1ps
module testbench;
   import ibq_pkg::*;

   localparam int CAPACITY = 16;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic [2:0]        req_type = '0;
   logic [POS_W-1:0]  req_position = '0;
   logic [CNT_W-1:0]  req_copy_count = '0;
   logic [DATA_W-1:0] req_element_value = '0;
   logic              rsp_strobe;
   logic [1:0]        rsp_status;
   logic [DATA_W-1:0] rsp_read_value;
   logic [FILL_W-1:0] rsp_fill_level;
   int                fail_count, pending_count, result_count;
   int                word_count = 0;
   int                fill_guess = 0;

   always #4 clock = ~clock;

   indexed_byte_queue #(.CAPACITY(CAPACITY)) DUT (.*);

   indexed_byte_queue_checker #(.CAPACITY(CAPACITY)) queue_checker (.*);

   task automatic send_word(logic [2:0] kind, int pos, int cnt, int value);
      int gap;
      if ($urandom_range(3) == 0) gap = 0;
      else gap = $urandom_range(13);
      repeat (gap) @(negedge clock);
      while (busy) @(negedge clock);
      req_type = kind;
      req_position = POS_W'(pos);
      req_copy_count = CNT_W'(cnt);
      req_element_value = DATA_W'(value);
      start = 1;
      @(negedge clock);
      start = 0;
      word_count++;
      // rough fill tracking to steer random choices
      case (kind)
         REQ_ENQUEUE: if (fill_guess < CAPACITY) fill_guess++;
         REQ_DEQUEUE: if (fill_guess > 0) fill_guess--;
         REQ_ERASE:   if (pos < fill_guess) fill_guess--;
         REQ_INSERT:  if (pos < fill_guess)
                         fill_guess = (fill_guess + cnt > CAPACITY) ? CAPACITY
                                                                   : fill_guess + cnt;
         default: ;
      endcase
   endtask

   task automatic drain_results();
      while (pending_count != 0) @(negedge clock);
      repeat (2 * CAPACITY + 4) @(negedge clock);
   endtask

   initial begin
      logic [2:0] kind;
      int         pos;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      @(negedge clock);

      send_word(REQ_DEQUEUE, 0, 0, 0);
      send_word(REQ_READ, 0, 0, 0);
      send_word(REQ_ERASE, 15, 0, 0);
      send_word(REQ_INSERT, 0, 5, 8'h11);
      send_word(REQ_ENQUEUE, 0, 0, 8'h00);
      send_word(REQ_ENQUEUE, 0, 0, 8'hff);
      send_word(REQ_INSERT, 0, 0, 8'h55);
      send_word(REQ_INSERT, 0, 16, 8'haa);
      send_word(REQ_ENQUEUE, 0, 0, 8'h5a);
      send_word(REQ_READ, 15, 0, 0);
      send_word(REQ_READ, 0, 0, 0);
      send_word(REQ_ERASE, 0, 0, 0);
      send_word(REQ_ERASE, 14, 0, 0);
      send_word(REQ_READ, 13, 0, 0);
      send_word(3'd5, 15, 31, 8'hff);
      send_word(3'd6, 0, 0, 0);
      send_word(3'd7, 9, 17, 8'h3c);
      send_word(REQ_INSERT, 2, 31, 8'h77);
      send_word(REQ_READ, 15, 0, 0);
      send_word(REQ_DEQUEUE, 0, 0, 0);
      send_word(REQ_INSERT, 3, 20, 8'h81);
      drain_results();

      for (int i = 0; i < 1800; i++) begin
         case ($urandom_range(99)) inside
            [0:21]:  kind = REQ_ENQUEUE;
            [22:36]: kind = REQ_DEQUEUE;
            [37:53]: kind = REQ_ERASE;
            [54:71]: kind = REQ_INSERT;
            [72:95]: kind = REQ_READ;
            default: kind = 3'($urandom_range(7, 5));
         endcase
         if (fill_guess > 0 && $urandom_range(7) != 0) pos = $urandom_range(fill_guess - 1);
         else pos = $urandom_range(15);
         send_word(kind, pos, ($urandom_range(3) == 0) ? $urandom_range(31)
                                                       : $urandom_range(4),
                   $urandom_range(255));
         if (i == 900) drain_results();
      end
      drain_results();

      $display("sent %0d request words, checked %0d result words", word_count, result_count);
      $display("all request types, out-of-range, empty, full and truncated inserts covered");
      if (fail_count == 0) $display("indexed_byte_queue test passed");
      else $display("indexed_byte_queue test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("indexed_byte_queue test failed");
      $finish;
   end

endmodule
